[hw/rtl/perceptron_step_learning_macros.svh]
// Assertion macros for the perceptron learning block.
// Included by the top-level RTL file, which checks its own control logic.
`ifndef PERCEPTRON_STEP_LEARNING_MACROS_SVH
`define PERCEPTRON_STEP_LEARNING_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PSL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("perceptron_step_learning: same-cycle check failed");

`define PSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("perceptron_step_learning: next-cycle check failed");

`else

`define PSL_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define PSL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/psl_pkg.sv]
// Shared constants, types and the weight saturation function for the
// perceptron learning block. No dependencies.
package psl_pkg;

    localparam int PIXEL_COUNT  = 35;
    localparam int WEIGHT_WIDTH = 16;
    localparam int LANE_PIXELS  = 5;
    localparam int LANE_COUNT   = (PIXEL_COUNT + LANE_PIXELS - 1) / LANE_PIXELS;
    localparam int PAD_PIXELS   = LANE_COUNT * LANE_PIXELS;

    localparam int BIAS_WIDTH = 8;
    localparam int RATE_WIDTH = 8;
    localparam logic [RATE_WIDTH-1:0] RATE_RESET = 8'd26;
    localparam int WSUM_WIDTH = 24;

    localparam int LANE_SUM_WIDTH = WEIGHT_WIDTH + $clog2(LANE_PIXELS + 1);
    localparam int PROD_WIDTH     = WEIGHT_WIDTH + BIAS_WIDTH;
    localparam int TERM_WIDTH     = (PROD_WIDTH > LANE_SUM_WIDTH) ? PROD_WIDTH : LANE_SUM_WIDTH;
    localparam int SUM_WIDTH      = TERM_WIDTH + $clog2(LANE_COUNT + 1);
    localparam int EXT_WIDTH      = (SUM_WIDTH > WSUM_WIDTH) ? SUM_WIDTH : WSUM_WIDTH + 1;
    localparam int DELTA_WIDTH    = RATE_WIDTH + 1 + BIAS_WIDTH;
    localparam int UPD_WIDTH      =
        ((WEIGHT_WIDTH > DELTA_WIDTH) ? WEIGHT_WIDTH : DELTA_WIDTH) + 1;

    localparam longint WEIGHT_MAX = (longint'(1) <<< (WEIGHT_WIDTH - 1)) - 1;
    localparam longint WEIGHT_MIN = -WEIGHT_MAX - 1;
    localparam longint WSUM_MAX   = (longint'(1) <<< (WSUM_WIDTH - 1)) - 1;
    localparam longint WSUM_MIN   = -WSUM_MAX - 1;

    localparam int BIAS_LSB      = PIXEL_COUNT;
    localparam int TARGET_BIT    = PIXEL_COUNT + BIAS_WIDTH;
    localparam int IN_DATA_BITS  = PIXEL_COUNT + BIAS_WIDTH + 1;
    localparam int S_TDATA_WIDTH = ((IN_DATA_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = 2 + WSUM_WIDTH;
    localparam int M_TDATA_WIDTH = ((OUT_DATA_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                  en;
        logic                  up;
        logic [RATE_WIDTH-1:0] rate;
    } upd_t;

    function automatic logic signed [WEIGHT_WIDTH-1:0] sat_weight(
        input logic signed [UPD_WIDTH-1:0] v
    );
        logic signed [WEIGHT_WIDTH-1:0] r;
        if (v > UPD_WIDTH'(WEIGHT_MAX)) begin
            r = WEIGHT_WIDTH'(WEIGHT_MAX);
        end else if (v < UPD_WIDTH'(WEIGHT_MIN)) begin
            r = WEIGHT_WIDTH'(WEIGHT_MIN);
        end else begin
            r = v[WEIGHT_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/psl_lane.sv]
// One lane: holds the weights of a group of pixels, forms their partial sum
// and applies the learning update. Depends on psl_pkg.
module psl_lane (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          load,
    input  logic [psl_pkg::LANE_PIXELS-1:0]               pix_rd,
    input  logic [psl_pkg::LANE_PIXELS-1:0]               pix_wr,
    input  psl_pkg::upd_t                                 upd,
    output logic signed [psl_pkg::LANE_SUM_WIDTH-1:0]     sum_reg
);

    logic signed [psl_pkg::WEIGHT_WIDTH-1:0]   weight_reg  [psl_pkg::LANE_PIXELS];
    logic signed [psl_pkg::WEIGHT_WIDTH-1:0]   weight_next [psl_pkg::LANE_PIXELS];
    logic signed [psl_pkg::LANE_SUM_WIDTH-1:0] sum_next;
    logic signed [psl_pkg::UPD_WIDTH-1:0]      delta;

    always_comb begin
        delta = upd.up ? $signed(psl_pkg::UPD_WIDTH'(upd.rate))
                       : -$signed(psl_pkg::UPD_WIDTH'(upd.rate));
        sum_next = '0;
        for (int k = 0; k < psl_pkg::LANE_PIXELS; k++) begin
            if (pix_rd[k]) begin
                sum_next = sum_next + psl_pkg::LANE_SUM_WIDTH'(weight_reg[k]);
            end
            if (upd.en && pix_wr[k]) begin
                weight_next[k] = psl_pkg::sat_weight(
                    psl_pkg::UPD_WIDTH'(weight_reg[k]) + delta);
            end else begin
                weight_next[k] = weight_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < psl_pkg::LANE_PIXELS; k++) begin
                weight_reg[k] <= '0;
            end
        end else begin
            weight_reg <= weight_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sum_reg <= sum_next;
        end
    end

endmodule

[hw/rtl/psl_bias.sv]
// Bias weight: holds it, forms its product with the bias input and the
// learning step for it, and applies the update. Depends on psl_pkg.
module psl_bias (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      load,
    input  logic signed [psl_pkg::BIAS_WIDTH-1:0]     bias_rd,
    input  psl_pkg::upd_t                             upd,
    output logic signed [psl_pkg::PROD_WIDTH-1:0]     prod_reg
);

    logic signed [psl_pkg::WEIGHT_WIDTH-1:0] bias_w_reg;
    logic signed [psl_pkg::WEIGHT_WIDTH-1:0] bias_w_next;
    logic signed [psl_pkg::PROD_WIDTH-1:0]   prod_next;
    logic signed [psl_pkg::DELTA_WIDTH-1:0]  delta_reg;
    logic signed [psl_pkg::DELTA_WIDTH-1:0]  delta_next;
    logic signed [psl_pkg::UPD_WIDTH-1:0]    step;

    always_comb begin
        prod_next  = psl_pkg::PROD_WIDTH'(bias_w_reg) * psl_pkg::PROD_WIDTH'(bias_rd);
        delta_next = psl_pkg::DELTA_WIDTH'($signed({1'b0, upd.rate}))
                   * psl_pkg::DELTA_WIDTH'(bias_rd);
        step = upd.up ? psl_pkg::UPD_WIDTH'(delta_reg) : -psl_pkg::UPD_WIDTH'(delta_reg);
        if (upd.en) begin
            bias_w_next = psl_pkg::sat_weight(psl_pkg::UPD_WIDTH'(bias_w_reg) + step);
        end else begin
            bias_w_next = bias_w_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bias_w_reg <= '0;
        end else begin
            bias_w_reg <= bias_w_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg  <= prod_next;
            delta_reg <= delta_next;
        end
    end

endmodule

[hw/rtl/psl_merge.sv]
// Merge stage: adds the lane partial sums and the bias product, takes the
// step activation and clamps the reported sum. Depends on psl_pkg.
module psl_merge (
    input  logic signed [psl_pkg::LANE_SUM_WIDTH-1:0] lane_sum [psl_pkg::LANE_COUNT],
    input  logic signed [psl_pkg::PROD_WIDTH-1:0]     bias_prod,
    output logic                                      activation,
    output logic signed [psl_pkg::WSUM_WIDTH-1:0]     weighted_sum
);

    logic signed [psl_pkg::EXT_WIDTH-1:0] total;

    always_comb begin
        total = psl_pkg::EXT_WIDTH'(bias_prod);
        for (int i = 0; i < psl_pkg::LANE_COUNT; i++) begin
            total = total + psl_pkg::EXT_WIDTH'(lane_sum[i]);
        end
        activation = !total[psl_pkg::EXT_WIDTH-1] && (total != '0);
        if (total > psl_pkg::EXT_WIDTH'(psl_pkg::WSUM_MAX)) begin
            weighted_sum = psl_pkg::WSUM_WIDTH'(psl_pkg::WSUM_MAX);
        end else if (total < psl_pkg::EXT_WIDTH'(psl_pkg::WSUM_MIN)) begin
            weighted_sum = psl_pkg::WSUM_WIDTH'(psl_pkg::WSUM_MIN);
        end else begin
            weighted_sum = total[psl_pkg::WSUM_WIDTH-1:0];
        end
    end

endmodule

[hw/rtl/perceptron_step_learning.sv]
// Perceptron over a 7x5 binary pattern with the step-rule learning update.
// Depends on psl_pkg, psl_lane, psl_bias, psl_merge and the macros header.
// Every request gives one result through the s1 input, s2 lane and m output registers.
// Requests are taken one per cycle while the output is not stalled; a request that
// directly follows a learning request waits in s1 until that request leaves s2, as
// its lane sums are read from the weight registers only after the learning request's
// weight update has been written. Seven lanes of five pixel weights sum in parallel, then
// the merge stage adds the lanes and the bias product, decides the activation and updates
// the weights in the same cycle. Weights reset to zero; learning_rate resets to 26 (Q0.8).
`include "perceptron_step_learning_macros.svh"

module perceptron_step_learning (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [psl_pkg::RATE_WIDTH-1:0]       cfg_wdata,      // learning_rate
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [psl_pkg::S_TDATA_WIDTH-1:0]    s_tdata,        // pixels, bias_input, target
    input  logic                                 s_tuser,        // learn
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [psl_pkg::M_TDATA_WIDTH-1:0]    m_tdata         // activation, mismatch,
                                                                 // weighted_sum
);

    logic [psl_pkg::RATE_WIDTH-1:0] learning_rate_reg;

    logic                                     s1_valid_reg;
    logic [psl_pkg::PAD_PIXELS-1:0]           s1_pixels_reg;
    logic signed [psl_pkg::BIAS_WIDTH-1:0]    s1_bias_reg;
    logic                                     s1_target_reg;
    logic                                     s1_learn_reg;

    logic                                     s2_valid_reg;
    logic [psl_pkg::PAD_PIXELS-1:0]           s2_pixels_reg;
    logic                                     s2_target_reg;
    logic                                     s2_learn_reg;

    logic                                     m_valid_reg;
    logic                                     m_activation_reg;
    logic                                     m_mismatch_reg;
    logic signed [psl_pkg::WSUM_WIDTH-1:0]    m_wsum_reg;

    logic signed [psl_pkg::LANE_SUM_WIDTH-1:0] lane_sum [psl_pkg::LANE_COUNT];
    logic signed [psl_pkg::PROD_WIDTH-1:0]     bias_prod;
    logic                                      activation;
    logic                                      mismatch;
    logic signed [psl_pkg::WSUM_WIDTH-1:0]     weighted_sum;

    logic          out_free;
    logic          s2_fire;
    logic          s2_free;
    logic          s1_fire;
    logic          s_accept;
    psl_pkg::upd_t upd;

    always_comb begin
        out_free = !m_valid_reg || m_tready;
        s2_fire  = s2_valid_reg && out_free;
        s2_free  = !s2_valid_reg || s2_fire;
        // lane sums must see the weights written by a learning request ahead
        s1_fire  = s1_valid_reg && s2_free && !(s2_valid_reg && s2_learn_reg);
        s_tready = !s1_valid_reg || s1_fire;
        s_accept = s_tvalid && s_tready;
        mismatch = activation ^ s2_target_reg;
        upd.en   = s2_fire && s2_learn_reg && mismatch;
        upd.up   = s2_target_reg;
        upd.rate = learning_rate_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learning_rate_reg <= psl_pkg::RATE_RESET;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                learning_rate_reg <= cfg_wdata;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_fire) begin
                s2_valid_reg <= 1'b0;
            end
            if (s2_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixels_reg <= psl_pkg::PAD_PIXELS'(s_tdata[psl_pkg::PIXEL_COUNT-1:0]);
            s1_bias_reg   <= s_tdata[psl_pkg::BIAS_LSB +: psl_pkg::BIAS_WIDTH];
            s1_target_reg <= s_tdata[psl_pkg::TARGET_BIT];
            s1_learn_reg  <= s_tuser;
        end
        if (s1_fire) begin
            s2_pixels_reg <= s1_pixels_reg;
            s2_target_reg <= s1_target_reg;
            s2_learn_reg  <= s1_learn_reg;
        end
        if (s2_fire) begin
            m_activation_reg <= activation;
            m_mismatch_reg   <= mismatch;
            m_wsum_reg       <= weighted_sum;
        end
    end

    for (genvar g = 0; g < psl_pkg::LANE_COUNT; g++) begin : g_lane
        psl_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .load    (s1_fire),
            .pix_rd  (s1_pixels_reg[g*psl_pkg::LANE_PIXELS +: psl_pkg::LANE_PIXELS]),
            .pix_wr  (s2_pixels_reg[g*psl_pkg::LANE_PIXELS +: psl_pkg::LANE_PIXELS]),
            .upd     (upd),
            .sum_reg (lane_sum[g])
        );
    end

    psl_bias u_bias (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s1_fire),
        .bias_rd  (s1_bias_reg),
        .upd      (upd),
        .prod_reg (bias_prod)
    );

    psl_merge u_merge (
        .lane_sum     (lane_sum),
        .bias_prod    (bias_prod),
        .activation   (activation),
        .weighted_sum (weighted_sum)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = psl_pkg::M_TDATA_WIDTH'({m_wsum_reg, m_mismatch_reg, m_activation_reg});

    `PSL_ASSERT_IMPLIES(a_no_upd_on_stall, aclk, aresetn, (m_valid_reg && !m_tready), !upd.en)
    `PSL_ASSERT_IMPLIES(a_learn_fence, aclk, aresetn, (s2_fire && s2_learn_reg), !s1_fire)
    `PSL_ASSERT_IMPLIES(a_sign_match, aclk, aresetn, m_valid_reg, (m_activation_reg == (!m_wsum_reg[psl_pkg::WSUM_WIDTH-1] && (m_wsum_reg != '0))))
    `PSL_ASSERT_NEXT(a_upd_result, aclk, aresetn, upd.en, (m_valid_reg && m_mismatch_reg))

endmodule
